/* hw/rtl/biquadratic_patch_tessellator_core_macros.svh */
// Assertion macros for the patch tessellator
`ifndef BIQUADRATIC_PATCH_TESSELLATOR_CORE_MACROS_SVH
`define BIQUADRATIC_PATCH_TESSELLATOR_CORE_MACROS_SVH

// same-cycle implication
`define BPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tessellator assertion failed");

// next-cycle implication
`define BPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tessellator assertion failed");

`endif

/* hw/rtl/bpt_pkg.sv */
package bpt_pkg;

    localparam int MAX_STEPS = 7;
    localparam int NATTR     = 10;
    localparam int NPTS      = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_STEPS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_Y = 2'd1;

    typedef struct packed {
        logic signed [31:0] ctrl_pos_x;
        logic signed [31:0] ctrl_pos_y;
        logic signed [31:0] ctrl_pos_z;
        logic signed [31:0] ctrl_nrm_x;
        logic signed [31:0] ctrl_nrm_y;
        logic signed [31:0] ctrl_nrm_z;
        logic signed [31:0] ctrl_tex_u;
        logic signed [31:0] ctrl_tex_v;
        logic signed [31:0] ctrl_lm_u;
        logic signed [31:0] ctrl_lm_v;
    } in_word_t;

    typedef struct packed {
        logic        [5:0]  vert_index;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_nrm_x;
        logic signed [31:0] out_nrm_y;
        logic signed [31:0] out_nrm_z;
        logic signed [31:0] out_tex_u;
        logic signed [31:0] out_tex_v;
        logic signed [31:0] out_lm_u;
        logic signed [31:0] out_lm_v;
        logic               last_vertex;
    } out_word_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
    } mac_ctl_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WGT  = 7'b0000010,
        S_RD   = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_RND  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    // k/steps in Q1.15, rounded half up
    function automatic logic [15:0] param_q15(input logic [2:0] k, input logic [2:0] steps);
        logic [15:0] r;
        r = 16'd0;
        if (k == steps) r = 16'd32768;
        else begin
            case (steps)
                3'd2: r = 16'd16384;
                3'd3: r = (k == 3'd1) ? 16'd10923 : 16'd21845;
                3'd4: r = {k[1:0], 13'd0};
                3'd5:
                begin
                    case (k)
                        3'd1: r = 16'd6554;
                        3'd2: r = 16'd13107;
                        3'd3: r = 16'd19661;
                        3'd4: r = 16'd26214;
                        default: r = 16'd0;
                    endcase
                end
                3'd6:
                begin
                    case (k)
                        3'd1: r = 16'd5461;
                        3'd2: r = 16'd10923;
                        3'd3: r = 16'd16384;
                        3'd4: r = 16'd21845;
                        3'd5: r = 16'd27307;
                        default: r = 16'd0;
                    endcase
                end
                3'd7:
                begin
                    case (k)
                        3'd1: r = 16'd4681;
                        3'd2: r = 16'd9362;
                        3'd3: r = 16'd14043;
                        3'd4: r = 16'd18725;
                        3'd5: r = 16'd23406;
                        3'd6: r = 16'd28087;
                        default: r = 16'd0;
                    endcase
                end
                default: r = 16'd0;
            endcase
            if (k == 3'd0) r = 16'd0;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/bpt_mac.sv */
module bpt_mac (
    input  logic               clk,
    input  bpt_pkg::mac_ctl_t  ctl,
    input  logic signed [31:0] operand,
    input  logic        [30:0] weight,
    output logic signed [31:0] result
);
    import bpt_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [65:0] biased;
    logic signed [35:0] shifted;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
            prod_reg <= operand * $signed({1'b0, weight});
        if (ctl.acc_en)
            acc_reg <= ctl.first ? 66'(prod_reg) : acc_reg + 66'(prod_reg);
    end

    // round half up to Q16.16, then saturate
    always_comb
    begin
        biased  = acc_reg + 66'sd536870912;
        shifted = 36'(biased >>> 30);
        if (shifted > 36'sd2147483647)
            result = 32'sh7fffffff;
        else if (shifted < -36'sd2147483648)
            result = 32'sh80000000;
        else
            result = shifted[31:0];
    end

endmodule

/* hw/rtl/biquadratic_patch_tessellator_core.sv */
// After the ninth point is taken, each grid row first computes its three column
// curves, then each vertex of the row. 9 points in, then (steps_y+1)*(steps_x+1)
// vertices, a step count of 0 counting as 1; each vertex forms its 3 weights, then
// 10 attributes, each as 3 serial multiply-accumulates on one shared MAC plus
// rounding, then an output state that holds until the word is taken.
// Input is not ready while a grid is being produced.
// Reset: asynchronous, active low; steps reset to 4, point count to 0.
module biquadratic_patch_tessellator_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bpt_pkg::in_word_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bpt_pkg::out_word_t   out_data,
    input  logic                 cfg_we,
    input  logic [bpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [2:0]           cfg_data
);
    import bpt_pkg::*;

    state_t      state_reg, state_next;
    logic [2:0]  steps_x_reg, steps_y_reg;
    logic [2:0]  sx_reg, sy_reg;
    logic [3:0]  load_cnt_reg;
    logic [2:0]  t_reg, s_reg;
    logic [1:0]  c_reg, j_reg, wk_reg;
    logic [3:0]  a_reg;
    logic        vert_phase_reg;
    logic [5:0]  vidx_reg;
    logic [30:0] wgt_reg [3];
    logic signed [31:0] attr_reg [NATTR];

    logic [NATTR*32-1:0] ctrl_mem [NPTS];
    logic [31:0]         col_mem  [3*NATTR];
    logic [NATTR*32-1:0] ctrl_rd_reg;
    logic [31:0]         col_rd_reg;

    logic [15:0] u_cur, w_cur, mul_a, mul_b;
    logic [31:0] wprod;
    logic [3:0]  ctrl_addr;
    logic [4:0]  col_addr;
    logic signed [31:0] operand, mac_res;
    mac_ctl_t    mac_ctl;
    logic        in_acc, out_acc;
    logic [2:0]  clamp_x, clamp_y;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign out_acc  = out_valid && out_ready;

    assign clamp_x = (steps_x_reg == 3'd0) ? 3'd1 : steps_x_reg;
    assign clamp_y = (steps_y_reg == 3'd0) ? 3'd1 : steps_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_x_reg <= 3'd4;
            steps_y_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_STEPS_X) steps_x_reg <= cfg_data;
            else if (cfg_index == REG_STEPS_Y) steps_y_reg <= cfg_data;
        end
    end

    // weights for the current parameter, one per cycle on a small multiplier
    assign u_cur = vert_phase_reg ? param_q15(s_reg, sx_reg) : param_q15(t_reg, sy_reg);
    assign w_cur = 16'(17'd32768 - {1'b0, u_cur});
    assign mul_a = (wk_reg == 2'd2) ? u_cur : w_cur;
    assign mul_b = (wk_reg == 2'd0) ? w_cur : u_cur;
    assign wprod = mul_a * mul_b;

    assign ctrl_addr = 4'(j_reg) * 4'd3 + 4'(c_reg);
    assign col_addr  = 5'(j_reg) * 5'd10 + 5'(a_reg);

    always_ff @(posedge clk)
    begin
        if (in_acc)
            ctrl_mem[load_cnt_reg] <= {in_data.ctrl_lm_v, in_data.ctrl_lm_u,
                                       in_data.ctrl_tex_v, in_data.ctrl_tex_u,
                                       in_data.ctrl_nrm_z, in_data.ctrl_nrm_y,
                                       in_data.ctrl_nrm_x, in_data.ctrl_pos_z,
                                       in_data.ctrl_pos_y, in_data.ctrl_pos_x};
        if (state_reg == S_RD)
        begin
            ctrl_rd_reg <= ctrl_mem[ctrl_addr];
            col_rd_reg  <= col_mem[col_addr];
        end
        if (state_reg == S_RND && !vert_phase_reg)
            col_mem[5'(c_reg) * 5'd10 + 5'(a_reg)] <= mac_res;
        if (state_reg == S_RND && vert_phase_reg)
            attr_reg[a_reg] <= mac_res;
        if (state_reg == S_WGT)
            wgt_reg[wk_reg] <= (wk_reg == 2'd1) ? {wprod[29:0], 1'b0} : wprod[30:0];
    end

    assign operand = vert_phase_reg ? $signed(col_rd_reg) : $signed(ctrl_rd_reg[a_reg*32 +: 32]);

    always_comb
    begin
        mac_ctl.mul_en = (state_reg == S_MUL);
        mac_ctl.acc_en = (state_reg == S_ACC);
        mac_ctl.first  = (j_reg == 2'd0);
    end

    bpt_mac u_mac (
        .clk     (clk),
        .ctl     (mac_ctl),
        .operand (operand),
        .weight  (wgt_reg[j_reg]),
        .result  (mac_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_acc && load_cnt_reg == 4'(NPTS - 1)) state_next = S_WGT;
            S_WGT:  if (wk_reg == 2'd2) state_next = S_RD;
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = (j_reg == 2'd2) ? S_RND : S_RD;
            S_RND:
            begin
                if (vert_phase_reg)
                    state_next = (a_reg == 4'(NATTR - 1)) ? S_OUT : S_RD;
                else if (a_reg == 4'(NATTR - 1) && c_reg == 2'd2)
                    state_next = S_WGT;
                else
                    state_next = S_RD;
            end
            S_OUT:
            begin
                if (out_acc)
                    state_next = (s_reg == sx_reg && t_reg == sy_reg) ? S_IDLE : S_WGT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_cnt_reg   <= 4'd0;
            sx_reg         <= 3'd1;
            sy_reg         <= 3'd1;
            t_reg          <= 3'd0;
            s_reg          <= 3'd0;
            c_reg          <= 2'd0;
            j_reg          <= 2'd0;
            wk_reg         <= 2'd0;
            a_reg          <= 4'd0;
            vert_phase_reg <= 1'b0;
            vidx_reg       <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (load_cnt_reg == 4'(NPTS - 1))
                        begin
                            load_cnt_reg   <= 4'd0;
                            sx_reg         <= clamp_x;
                            sy_reg         <= clamp_y;
                            t_reg          <= 3'd0;
                            s_reg          <= 3'd0;
                            c_reg          <= 2'd0;
                            a_reg          <= 4'd0;
                            j_reg          <= 2'd0;
                            wk_reg         <= 2'd0;
                            vert_phase_reg <= 1'b0;
                            vidx_reg       <= 6'd0;
                        end
                        else
                            load_cnt_reg <= load_cnt_reg + 4'd1;
                    end
                end
                S_WGT:  wk_reg <= (wk_reg == 2'd2) ? 2'd0 : wk_reg + 2'd1;
                S_ACC:  j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
                S_RND:
                begin
                    if (a_reg == 4'(NATTR - 1))
                    begin
                        a_reg <= 4'd0;
                        if (!vert_phase_reg)
                        begin
                            if (c_reg == 2'd2)
                            begin
                                c_reg          <= 2'd0;
                                vert_phase_reg <= 1'b1;
                                s_reg          <= 3'd0;
                            end
                            else
                                c_reg <= c_reg + 2'd1;
                        end
                    end
                    else
                        a_reg <= a_reg + 4'd1;
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        vidx_reg <= vidx_reg + 6'd1;
                        if (s_reg == sx_reg)
                        begin
                            vert_phase_reg <= 1'b0;
                            t_reg          <= t_reg + 3'd1;
                        end
                        else
                            s_reg <= s_reg + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_data.vert_index  = vidx_reg;
        out_data.out_pos_x   = attr_reg[0];
        out_data.out_pos_y   = attr_reg[1];
        out_data.out_pos_z   = attr_reg[2];
        out_data.out_nrm_x   = attr_reg[3];
        out_data.out_nrm_y   = attr_reg[4];
        out_data.out_nrm_z   = attr_reg[5];
        out_data.out_tex_u   = attr_reg[6];
        out_data.out_tex_v   = attr_reg[7];
        out_data.out_lm_u    = attr_reg[8];
        out_data.out_lm_v    = attr_reg[9];
        out_data.last_vertex = (s_reg == sx_reg) && (t_reg == sy_reg);
    end

endmodule

/* hw/rtl/bpt_checker.sv */
`include "biquadratic_patch_tessellator_core_macros.svh"

module bpt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input bpt_pkg::out_word_t out_data
);
    import bpt_pkg::*;

    // a word on the output holds while stalled
    `BPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // no new points are taken while a grid is going out
    `BPT_ASSERT_NOW(a_busy, out_valid, !in_ready)
    // the grid ends on its last word, after which input opens again
    `BPT_ASSERT_NEXT(a_last_done, out_valid && out_ready && out_data.last_vertex, in_ready)
    // a point taken is never followed at once by an output word
    `BPT_ASSERT_NEXT(a_no_early_word, in_valid && in_ready, !out_valid)

endmodule

bind biquadratic_patch_tessellator_core bpt_checker u_bpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* test/biquadratic_patch_tessellator_core_tb.sv */
`timescale 1ns / 1ps

module biquadratic_patch_tessellator_core_tb;
    import bpt_pkg::*;

    localparam int RUN_LIMIT_NS = 40_000_000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_word_t in_data;
    logic out_valid;
    logic out_ready;
    out_word_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [2:0] cfg_data;

    biquadratic_patch_tessellator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    in_word_t point_queue[$];
    out_word_t vertex_queue[$];
    longint ctrl_pts[9][10];
    int points_held;
    logic [2:0] steps_x_reg;
    logic [2:0] steps_y_reg;
    int error_count;
    int vertices_seen;
    int grids_seen;
    bit bursts_on;
    bit in_taken;
    int in_gap;
    int out_gap;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [2:0] clamp_steps(input logic [2:0] v);
        if (v == 3'd0) return 3'd1;
        return v;
    endfunction

    function automatic longint q15_param(input int k, input int steps);
        return (longint'(k) * 65536 + steps) / (2 * steps);
    endfunction

    // weights sum to 2^30; round half up, then clamp to 32 bits
    function automatic longint bezier_blend(input longint p0, input longint p1,
                                            input longint p2, input longint u);
        longint w;
        longint acc;
        longint r;
        w = 32768 - u;
        acc = p0 * (w * w) + p1 * (2 * w * u) + p2 * (u * u);
        r = (acc + (longint'(1) << 29)) >>> 30;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic longint attr_of(input in_word_t w, input int a);
        logic signed [31:0] f[10];
        f = '{w.ctrl_pos_x, w.ctrl_pos_y, w.ctrl_pos_z, w.ctrl_nrm_x, w.ctrl_nrm_y,
              w.ctrl_nrm_z, w.ctrl_tex_u, w.ctrl_tex_v, w.ctrl_lm_u, w.ctrl_lm_v};
        return longint'(f[a]);
    endfunction

    task automatic take_point(input in_word_t w);
        int sx;
        int sy;
        int n;
        longint col[3][10];
        longint v[10];
        out_word_t o;
        for (int a = 0; a < 10; a++) ctrl_pts[points_held][a] = attr_of(w, a);
        if (points_held < 8) begin
            points_held++;
            return;
        end
        points_held = 0;
        sx = clamp_steps(steps_x_reg);
        sy = clamp_steps(steps_y_reg);
        n = 0;
        for (int t = 0; t <= sy; t++) begin
            for (int c = 0; c < 3; c++)
                for (int a = 0; a < 10; a++)
                    col[c][a] = bezier_blend(ctrl_pts[c][a], ctrl_pts[3+c][a],
                                             ctrl_pts[6+c][a], q15_param(t, sy));
            for (int s = 0; s <= sx; s++) begin
                for (int a = 0; a < 10; a++)
                    v[a] = bezier_blend(col[0][a], col[1][a], col[2][a], q15_param(s, sx));
                o.vert_index = n[5:0];
                o.out_pos_x = v[0][31:0]; o.out_pos_y = v[1][31:0];
                o.out_pos_z = v[2][31:0]; o.out_nrm_x = v[3][31:0];
                o.out_nrm_y = v[4][31:0]; o.out_nrm_z = v[5][31:0];
                o.out_tex_u = v[6][31:0]; o.out_tex_v = v[7][31:0];
                o.out_lm_u = v[8][31:0]; o.out_lm_v = v[9][31:0];
                n++;
                o.last_vertex = (n == (sx + 1) * (sy + 1));
                vertex_queue.push_back(o);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch vertex %0d %s: got %0h want %0h", vertices_seen, what, got, want);
    endtask

    // input side: a point counts once it is taken at the rising edge
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            take_point(in_data);
            in_taken = 1'b1;
        end
    end

    // driver: falling edge, payload held until taken
    always @(negedge clk) begin
        bit took;
        took = in_taken;
        in_taken = 1'b0;
        if (rst_n) begin
            if (took)
                void'(point_queue.pop_front());
            if (!in_valid || took) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                    in_gap <= $urandom_range(1, 6) - 1;
                    in_valid <= 1'b0;
                end else if (point_queue.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= point_queue[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 4) == 0) begin
                out_gap <= $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        out_word_t want;
        if (rst_n && out_valid && out_ready) begin
            if (vertex_queue.size() == 0) begin
                report_mismatch("unexpected", out_data.vert_index, 0);
            end else begin
                want = vertex_queue.pop_front();
                if (out_data.vert_index != want.vert_index)
                    report_mismatch("vert_index", out_data.vert_index, want.vert_index);
                if (out_data.out_pos_x != want.out_pos_x)
                    report_mismatch("pos_x", out_data.out_pos_x, want.out_pos_x);
                if (out_data.out_pos_y != want.out_pos_y)
                    report_mismatch("pos_y", out_data.out_pos_y, want.out_pos_y);
                if (out_data.out_pos_z != want.out_pos_z)
                    report_mismatch("pos_z", out_data.out_pos_z, want.out_pos_z);
                if (out_data.out_nrm_x != want.out_nrm_x)
                    report_mismatch("nrm_x", out_data.out_nrm_x, want.out_nrm_x);
                if (out_data.out_nrm_y != want.out_nrm_y)
                    report_mismatch("nrm_y", out_data.out_nrm_y, want.out_nrm_y);
                if (out_data.out_nrm_z != want.out_nrm_z)
                    report_mismatch("nrm_z", out_data.out_nrm_z, want.out_nrm_z);
                if (out_data.out_tex_u != want.out_tex_u)
                    report_mismatch("tex_u", out_data.out_tex_u, want.out_tex_u);
                if (out_data.out_tex_v != want.out_tex_v)
                    report_mismatch("tex_v", out_data.out_tex_v, want.out_tex_v);
                if (out_data.out_lm_u != want.out_lm_u)
                    report_mismatch("lm_u", out_data.out_lm_u, want.out_lm_u);
                if (out_data.out_lm_v != want.out_lm_v)
                    report_mismatch("lm_v", out_data.out_lm_v, want.out_lm_v);
                if (out_data.last_vertex != want.last_vertex)
                    report_mismatch("last_vertex", out_data.last_vertex, want.last_vertex);
                if (want.last_vertex) grids_seen++;
            end
            vertices_seen++;
        end
    end

    function automatic logic signed [31:0] rand_attr(input int mode);
        case (mode)
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return $signed(32'($urandom_range(0, 2 * 65536)) - 32'sd65536);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic in_word_t make_point(input int mode);
        in_word_t w;
        int m;
        logic signed [31:0] f[10];
        for (int a = 0; a < 10; a++) begin
            m = (mode < 0) ? $urandom_range(0, 7) : mode;
            f[a] = rand_attr(m > 4 ? 4 : m);
        end
        w = '{f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]};
        return w;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_STEPS_X) steps_x_reg = val;
        else if (idx == REG_STEPS_Y) steps_y_reg = val;
    endtask

    // wait for the grid to drain before touching registers
    task automatic drain();
        while (point_queue.size() > 0 || in_valid || vertex_queue.size() > 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic push_patch(input int mode);
        for (int i = 0; i < 9; i++) point_queue.push_back(make_point(mode));
    endtask

    initial begin
        logic [2:0] sx;
        logic [2:0] sy;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        points_held = 0;
        steps_x_reg = 3'd4;
        steps_y_reg = 3'd4;
        error_count = 0;
        vertices_seen = 0;
        grids_seen = 0;
        bursts_on = 1'b1;
        in_taken = 1'b0;
        in_gap = 0;
        out_gap = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset steps, then extremes of the data
        push_patch(0);
        drain();
        write_reg(REG_STEPS_X, 3'd0);
        write_reg(REG_STEPS_Y, 3'd7);
        push_patch(1);
        drain();
        // out-of-range index must be ignored
        write_reg(2'd3, 3'd1);
        write_reg(REG_STEPS_X, 3'd7);
        write_reg(REG_STEPS_Y, 3'd0);
        push_patch(-1);
        drain();

        // random patches, mostly small grids
        for (int p = 0; p < 10; p++) begin
            sx = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(0, 3));
            sy = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(0, 3));
            write_reg(REG_STEPS_X, sx);
            write_reg(REG_STEPS_Y, sy);
            if (p >= 7) bursts_on = 1'b0;
            push_patch(p == 4 ? 3 : -1);
            drain();
        end

        $display("covered %0d patches, %0d vertices checked, step counts 0 to 7",
                 grids_seen, vertices_seen);
        if (error_count == 0)
            $display("PASS biquadratic_patch_tessellator_core");
        else
            $display("FAIL biquadratic_patch_tessellator_core");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL biquadratic_patch_tessellator_core");
        $finish;
    end
endmodule
